@@ sv/assert_macros.svh @@
// Assertion macros shared by the cache RTL; clk and rst_n are taken from the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, expr)

`define ASSERT_IMPL(lbl, ante, cons)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ sv/lkc_pkg.sv @@
// Shared constants, types and codes of the keyed-entry LRU cache.
`timescale 1ns / 1ps

package lkc_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int NODE_W    = 32;
  localparam int OFFS_W    = 24;
  localparam int LAYOUT_W  = 36;
  localparam int METRICS_W = 60;
  localparam int IN_DATA_W = 120;
  localparam int OUT_DATA_W = 16;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(5);

  localparam logic [1:0] MODE_LOOKUP  = 2'd0;
  localparam logic [1:0] MODE_INVAL   = 2'd1;
  localparam logic [1:0] MODE_METRICS = 2'd2;

  typedef struct packed {
    logic [LAYOUT_W-1:0] layout;
    logic [OFFS_W-1:0]   offset;
    logic [NODE_W-1:0]   node;
  } key_t;

  // commands from the sequencer to the recency unit
  typedef struct packed {
    logic             clear;
    logic             evict_start;
    logic             touch;
    logic             insert;
    logic [IDX_W-1:0] slot;
  } lru_cmd_t;

  typedef struct packed {
    logic               evict_done;
    logic [IDX_W-1:0]   victim;
    logic [CNT_W-1:0]   count;
    logic [ENTRIES-1:0] valid;
  } lru_stat_t;

endpackage

@@ sv/lru_keyed_entry_cache.sv @@
// Top level of the fully associative LRU page-location cache and its sequencer.
//
// Use: one item per in_ beat (mode in in_tuser, key and metrics in in_tdata),
// one result beat per item on out_ (hit, slot, evicted count, cleared flag).
// cfg_we/cfg_wdata write the capacity (0 acts as 1, above 16 acts as 16);
// write it only while the block is idle.
// Each tag lookup scans the 16 tag memory entries one per cycle through
// a single read port and comparator before the decision; a hit or a miss
// into a free slot then updates the recency ranks. Every eviction runs a rank
// scan over all 16 entries followed by an update, so a miss into a full cache
// adds one eviction, and so does each entry trimmed after a capacity cut.
// Invalidate and metrics items skip the tag scan. A new item is taken only once
// the previous one has finished, in the cycle after its result is loaded.
// Reset empties the cache, zeroes the stored metrics and sets capacity to 5;
// no clearing pass is needed. The result sits in an output register, so the next
// item is taken while it waits; if out_tready stays low the sequencer holds its
// finished result until the register frees up.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lru_keyed_entry_cache
  import lkc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata,   // capacity
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // node ref, char offset, left, right, top and bottom margins,
  // screen w, screen h, spacing, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,    // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata    // hit, slot, evicted_count, cleared, zero fill
);

  typedef enum logic [3:0] {
    S_IDLE, S_TRIM, S_TRIM_EV, S_LOOK, S_LOOK_END, S_DECIDE,
    S_HIT, S_MISS_EV, S_INSERT, S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cap_r;
  logic [CNT_W-1:0]       cap_eff;
  logic [1:0]             mode_r;
  key_t                   key_r;
  key_t                   in_key;
  logic [METRICS_W-1:0]   metrics_r;
  logic [METRICS_W-1:0]   in_metrics;
  logic [METRICS_W-1:0]   stored_metrics_r;

  logic [IDX_W-1:0]       idx_r;
  logic                   cmp_vld_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic                   found_r;
  logic [IDX_W-1:0]       fslot_r;
  logic                   free_vld_r;
  logic [IDX_W-1:0]       free_r;

  logic                   hit_r;
  logic [IDX_W-1:0]       slot_r;
  logic [CNT_W-1:0]       evc_r;
  logic                   clr_r;
  logic                   out_tvalid_r;
  logic [OUT_DATA_W-1:0]  out_tdata_r;

  lru_cmd_t               lru_cmd;
  lru_stat_t              lru_st;
  logic                   tag_eq;
  logic                   tag_wr;
  logic                   out_free;

  logic [7:0] f_ml, f_mr, f_mt, f_mb, f_ls;
  logic [9:0] f_sw, f_sh;

  assign f_ml = in_tdata[63:56];
  assign f_mr = in_tdata[71:64];
  assign f_mt = in_tdata[79:72];
  assign f_mb = in_tdata[87:80];
  assign f_sw = in_tdata[97:88];
  assign f_sh = in_tdata[107:98];
  assign f_ls = in_tdata[115:108];

  assign in_key.node   = in_tdata[31:0];
  assign in_key.offset = in_tdata[55:32];
  assign in_key.layout = {f_sh, f_sw, f_mr, f_ml};
  assign in_metrics    = {f_ls, f_mb, f_mt, f_mr, f_ml, f_sh, f_sw};

  assign cap_eff = (cap_r == '0) ? CNT_W'(1)
                 : (cap_r > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : cap_r;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;
  assign tag_wr    = (state_r == S_INSERT);

  lkc_tag_store u_tags (
    .clk     (clk),
    .rd_addr (idx_r),
    .wr_en   (tag_wr),
    .wr_addr (free_r),
    .wr_key  (key_r),
    .cmp_key (key_r),
    .tag_eq  (tag_eq)
  );

  lkc_lru u_lru (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (lru_cmd),
    .stat  (lru_st)
  );

  always_comb begin
    state_nxt = state_r;
    lru_cmd   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_TRIM;
      end
      S_TRIM: begin
        if (lru_st.count > cap_eff) begin
          lru_cmd.evict_start = 1'b1;
          state_nxt = S_TRIM_EV;
        end else begin
          case (mode_r)
            MODE_LOOKUP: state_nxt = S_LOOK;
            MODE_INVAL: begin
              lru_cmd.clear = 1'b1;
              state_nxt = S_DONE;
            end
            MODE_METRICS: begin
              lru_cmd.clear = (metrics_r != stored_metrics_r);
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_TRIM_EV: begin
        if (lru_st.evict_done) state_nxt = S_TRIM;
      end
      S_LOOK: begin
        if (idx_r == IDX_W'(ENTRIES - 1)) state_nxt = S_LOOK_END;
      end
      S_LOOK_END: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (found_r) begin
          state_nxt = S_HIT;
        end else if (lru_st.count >= cap_eff) begin
          lru_cmd.evict_start = 1'b1;
          state_nxt = S_MISS_EV;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_HIT: begin
        lru_cmd.touch = 1'b1;
        lru_cmd.slot  = fslot_r;
        state_nxt = S_DONE;
      end
      S_MISS_EV: begin
        if (lru_st.evict_done) state_nxt = S_INSERT;
      end
      S_INSERT: begin
        lru_cmd.insert = 1'b1;
        lru_cmd.slot   = free_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      cap_r            <= CAP_RESET;
      stored_metrics_r <= '0;
      out_tvalid_r     <= 1'b0;
      cmp_vld_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cap_r <= cfg_wdata;

      if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;

      // compare stage sees the tag read address of the previous cycle
      cmp_vld_r <= (state_r == S_LOOK);
      cmp_idx_r <= idx_r;
      if (cmp_vld_r) begin
        if (lru_st.valid[cmp_idx_r] && tag_eq && !found_r) begin
          found_r <= 1'b1;
          fslot_r <= cmp_idx_r;
        end
        if (!lru_st.valid[cmp_idx_r] && !free_vld_r) begin
          free_vld_r <= 1'b1;
          free_r     <= cmp_idx_r;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r    <= in_tuser;
            key_r     <= in_key;
            metrics_r <= in_metrics;
            hit_r     <= 1'b0;
            slot_r    <= '0;
            evc_r     <= '0;
            clr_r     <= 1'b0;
          end
        end
        S_TRIM: begin
          idx_r      <= '0;
          found_r    <= 1'b0;
          free_vld_r <= 1'b0;
          if (lru_st.count <= cap_eff) begin
            if (mode_r == MODE_INVAL) begin
              clr_r <= 1'b1;
            end else if (mode_r == MODE_METRICS && metrics_r != stored_metrics_r) begin
              clr_r            <= 1'b1;
              stored_metrics_r <= metrics_r;
            end
          end
        end
        S_TRIM_EV: begin
          if (lru_st.evict_done) evc_r <= evc_r + 1'b1;
        end
        S_LOOK: begin
          idx_r <= idx_r + 1'b1;
        end
        S_MISS_EV: begin
          if (lru_st.evict_done) begin
            evc_r <= evc_r + 1'b1;
            // the freed victim slot may lie below the first free one
            if (!free_vld_r || (lru_st.victim < free_r)) begin
              free_r <= lru_st.victim;
            end
            free_vld_r <= 1'b1;
          end
        end
        S_HIT: begin
          hit_r  <= 1'b1;
          slot_r <= fslot_r;
        end
        S_INSERT: begin
          slot_r <= free_r;
        end
        S_DONE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {(OUT_DATA_W - 2 - IDX_W - CNT_W)'(0), clr_r, evc_r, slot_r, hit_r};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `ASSERT_IMPL(a_trimmed_before_lookup, state_r == S_LOOK, lru_st.count <= cap_eff)
  `ASSERT_IMPL(a_room_at_insert, state_r == S_INSERT, (lru_st.count < cap_eff) && free_vld_r)
  `ASSERT_IMPL(a_evict_done_expected, lru_st.evict_done,
               (state_r == S_TRIM_EV) || (state_r == S_MISS_EV))

endmodule

@@ sv/lkc_tag_store.sv @@
// Tag memory of the cache with registered read and key comparator.
`timescale 1ns / 1ps

module lkc_tag_store
  import lkc_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  key_t             wr_key,
  input  key_t             cmp_key,
  output logic             tag_eq
);

  key_t mem [ENTRIES];
  key_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_key;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign tag_eq = (rd_data_r == cmp_key);

endmodule

@@ sv/lkc_lru.sv @@
// Valid bits, recency ranks, entry count and the oldest-entry scan.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lkc_lru
  import lkc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  lru_cmd_t  cmd,
  output lru_stat_t stat
);

  logic [ENTRIES-1:0] valid_r;
  logic [IDX_W-1:0]   rank_r [ENTRIES];
  logic [CNT_W-1:0]   count_r;

  logic               scan_r;
  logic               apply_r;
  logic [IDX_W-1:0]   sidx_r;
  logic [IDX_W-1:0]   best_r;
  logic               have_r;
  logic [IDX_W-1:0]   victim_r;

  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   rank_rd;
  logic               take;

  // one rank read port: scan index while scanning, else the touched slot
  assign rd_idx  = scan_r ? sidx_r : cmd.slot;
  assign rank_rd = rank_r[rd_idx];
  assign take    = valid_r[sidx_r] && (!have_r || (rank_rd > best_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      scan_r  <= 1'b0;
      apply_r <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      apply_r <= 1'b0;
      if (cmd.evict_start) begin
        scan_r <= 1'b1;
        sidx_r <= '0;
        have_r <= 1'b0;
      end else if (scan_r) begin
        if (take) begin
          have_r   <= 1'b1;
          best_r   <= rank_rd;
          victim_r <= sidx_r;
        end
        if (sidx_r == IDX_W'(ENTRIES - 1)) begin
          scan_r  <= 1'b0;
          apply_r <= 1'b1;
        end
        sidx_r <= sidx_r + 1'b1;
      end

      if (apply_r && have_r) begin
        valid_r[victim_r] <= 1'b0;
        count_r           <= count_r - 1'b1;
      end

      if (cmd.clear) begin
        valid_r <= '0;
        count_r <= '0;
      end

      if (cmd.touch) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (rank_r[i] < rank_rd)) begin
            rank_r[i] <= rank_r[i] + 1'b1;
          end
        end
        rank_r[cmd.slot] <= '0;
      end

      if (cmd.insert) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i]) begin
            rank_r[i] <= rank_r[i] + 1'b1;
          end
        end
        rank_r[cmd.slot]  <= '0;
        valid_r[cmd.slot] <= 1'b1;
        count_r           <= count_r + 1'b1;
      end
    end
  end

  assign stat.evict_done = apply_r;
  assign stat.victim     = victim_r;
  assign stat.count      = count_r;
  assign stat.valid      = valid_r;

  `ASSERT_ALWAYS(a_count_matches_valid, $countones(valid_r) == count_r)
  `ASSERT_IMPL(a_insert_into_free, cmd.insert, !valid_r[cmd.slot])
  `ASSERT_NEXT(a_scan_ends_in_apply, scan_r && (sidx_r == IDX_W'(ENTRIES - 1)) && !cmd.evict_start,
               apply_r)

endmodule
